/* rtl/cbm_pkg.sv */
// Shared types, codes and constants for the control binding mapper.
`timescale 1ns / 1ps
`default_nettype none
package cbm_pkg;

   localparam int DEFAULT_PLAYERS = 2;
   localparam int DEFAULT_SLOTS   = 16;
   localparam int STATES_W        = 32;

   localparam logic [2:0] OP_KEY    = 3'd0;
   localparam logic [2:0] OP_AXIS   = 3'd1;
   localparam logic [2:0] OP_HAT    = 3'd2;
   localparam logic [2:0] OP_BUTTON = 3'd3;
   localparam logic [2:0] OP_FRAME  = 3'd4;
   localparam logic [2:0] OP_ARM    = 3'd5;
   localparam logic [2:0] OP_WRITE  = 3'd6;

   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_AXIS   = 2'd1;
   localparam logic [1:0] KIND_HAT    = 2'd2;
   localparam logic [1:0] KIND_BUTTON = 2'd3;

   localparam logic [1:0] PS_IDLE     = 2'd0;
   localparam logic [1:0] PS_PRESSED  = 2'd1;
   localparam logic [1:0] PS_HELD     = 2'd2;
   localparam logic [1:0] PS_RELEASED = 2'd3;

   localparam logic signed [15:0] AXIS_HI = 16'sd16383;
   localparam logic signed [15:0] AXIS_LO = -16'sd16384;
   localparam logic [7:0]         KEY_DEVICE = 8'hFF;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         device;
      logic [30:0]        index;
      logic signed [15:0] threshold;
   } entry_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         device;
      logic [30:0]        index;
      logic signed [15:0] value;
   } evt_type;

   typedef struct packed {
      logic sel;
      logic hit;
   } match_type;

endpackage
`default_nettype wire

/* rtl/cbm_req_if.sv */
// Request and response channel interfaces for the control binding mapper.
`timescale 1ns / 1ps
`default_nettype none
interface cbm_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic [7:0]         device;
   logic [30:0]        control_index;
   logic signed [15:0] value;
   logic               player;
   logic [3:0]         slot;
   logic [1:0]         bind_kind;
   logic signed [15:0] bind_threshold;

   modport source (output valid, opcode, device, control_index, value, player, slot,
                   bind_kind, bind_threshold, input ready);
   modport sink (input valid, opcode, device, control_index, value, player, slot,
                 bind_kind, bind_threshold, output ready);
endinterface

interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic        report;
   logic        report_player;
   logic [31:0] press_states;
   logic        captured;
   logic        last;

   modport source (output valid, report, report_player, press_states, captured, last,
                   input ready);
   modport sink (input valid, report, report_player, press_states, captured, last,
                 output ready);
endinterface
`default_nettype wire

/* rtl/cbm_match.sv */
// Match unit: tests one binding entry against the current event.
`timescale 1ns / 1ps
`default_nettype none
module cbm_match (
   input  wire cbm_pkg::entry_type entry,
   input  wire                     bound,
   input  wire cbm_pkg::evt_type   evt,
   output cbm_pkg::match_type      result
);

   logic same_ctl;
   logic same_dev;

   assign same_ctl = (entry.kind == evt.kind) && (entry.index == evt.index);
   assign same_dev = (evt.kind == cbm_pkg::KIND_KEY) || (entry.device == evt.device);

   always_comb begin
      result.sel = bound && same_ctl && same_dev;
      unique case (evt.kind)
         cbm_pkg::KIND_AXIS: begin
            if (entry.threshold >= 16'sd0) result.hit = evt.value >= entry.threshold;
            else result.hit = evt.value <= entry.threshold;
         end
         cbm_pkg::KIND_HAT: result.hit = |(entry.threshold & evt.value);
         default:           result.hit = evt.value != 16'sd0;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/control_binding_mapper.sv */
// Top level: binding table, event scan sequencer and frame press-state reports.
// Flow: key/axis/hat/button events scan the whole table; a captured event, arm,
//   write or unused opcode goes from DECODE straight to ACK; a frame tick gives
//   PLAYERS reports, one per cycle while the response channel is not back-pressured.
// Throughput: one request at a time; the scan through the binding memory's single
//   read port, one entry per cycle through one match unit, sets the event rate.
// Reset (synchronous): all entries unbound, raw and press states idle, rebind disarmed.
`timescale 1ns / 1ps
`default_nettype none
module control_binding_mapper #(
   parameter int PLAYERS = cbm_pkg::DEFAULT_PLAYERS,
   parameter int SLOTS   = cbm_pkg::DEFAULT_SLOTS
) (
   input wire        clock,
   input wire        reset,
   cbm_req_if.sink   req_ch,
   cbm_rsp_if.source rsp_ch
);

   localparam int ENTRIES = PLAYERS * SLOTS;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int EW      = AW + 1;
   localparam int PW      = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_ACK,
      ST_REPORT
   } state_type;

   state_type state_ff;

   // latched request
   logic [2:0]         op_ff;
   logic [7:0]         dev_ff;
   logic [30:0]        idx_ff;
   logic signed [15:0] val_ff;
   logic               pl_ff;
   logic [3:0]         sl_ff;
   logic [1:0]         bkind_ff;
   logic signed [15:0] bthr_ff;

   // table state
   cbm_pkg::entry_type       bind_mem_ff [ENTRIES];
   cbm_pkg::entry_type       rdata_ff;
   logic [ENTRIES-1:0]       bound_ff;
   logic [ENTRIES-1:0]       raw_ff;
   logic [ENTRIES-1:0][1:0]  press_ff;
   logic                     armed_ff;
   logic [AW-1:0]            armed_ent_ff;

   // scan pipeline
   logic [EW-1:0] scan_ff;
   logic          cmp_vld_ff;
   logic [AW-1:0] cmp_idx_ff;
   logic          cmp_bound_ff;
   logic          cap_ff;
   logic [PW-1:0] rp_ff;

   // response register
   logic        rsp_valid_ff;
   logic        rsp_report_ff;
   logic        rsp_player_ff;
   logic [31:0] rsp_states_ff;
   logic        rsp_captured_ff;
   logic        rsp_last_ff;

   logic               rsp_free;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   cbm_pkg::entry_type mem_wdata;
   logic [EW-1:0]      ent_wide;
   logic [AW-1:0]      req_ent;
   logic               in_range;
   logic               is_event;
   logic               qualify;
   cbm_pkg::entry_type cap_entry;
   cbm_pkg::evt_type   evt;
   cbm_pkg::match_type match;
   logic [31:0]        report_word;
   logic               rpt_last;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.report        = rsp_report_ff;
   assign rsp_ch.report_player = rsp_player_ff;
   assign rsp_ch.press_states  = rsp_states_ff;
   assign rsp_ch.captured      = rsp_captured_ff;
   assign rsp_ch.last          = rsp_last_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // entry addressed by arm / write, player-major
   assign ent_wide = EW'(pl_ff) * EW'(SLOTS) + EW'(sl_ff);
   assign req_ent  = ent_wide[AW-1:0];
   assign in_range = ({1'b0, sl_ff} < 5'(SLOTS)) && ({2'b00, pl_ff} < 3'(PLAYERS));
   assign is_event = (op_ff == cbm_pkg::OP_KEY) || (op_ff == cbm_pkg::OP_AXIS) ||
                     (op_ff == cbm_pkg::OP_HAT) || (op_ff == cbm_pkg::OP_BUTTON);

   // rebind capture: which events qualify and what gets stored
   always_comb begin
      qualify             = 1'b0;
      cap_entry.kind      = op_ff[1:0];
      cap_entry.device    = dev_ff;
      cap_entry.index     = idx_ff;
      cap_entry.threshold = 16'sd0;
      unique case (op_ff)
         cbm_pkg::OP_KEY: begin
            qualify          = val_ff != 16'sd0;
            cap_entry.device = cbm_pkg::KEY_DEVICE;
         end
         cbm_pkg::OP_BUTTON: qualify = val_ff != 16'sd0;
         cbm_pkg::OP_AXIS: begin
            if (val_ff >= cbm_pkg::AXIS_HI) begin
               qualify             = 1'b1;
               cap_entry.threshold = cbm_pkg::AXIS_HI;
            end else if (val_ff <= cbm_pkg::AXIS_LO) begin
               qualify             = 1'b1;
               cap_entry.threshold = cbm_pkg::AXIS_LO;
            end
         end
         cbm_pkg::OP_HAT: begin
            qualify = (val_ff == 16'sd1) || (val_ff == 16'sd2) ||
                      (val_ff == 16'sd4) || (val_ff == 16'sd8);
            cap_entry.threshold = val_ff;
         end
         default: qualify = 1'b0;
      endcase
   end

   // table write port: capture or explicit binding write, both from DECODE
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_ent;
      mem_wdata = cap_entry;
      if (state_ff == ST_DECODE) begin
         if (is_event && armed_ff && qualify) begin
            mem_we    = 1'b1;
            mem_waddr = armed_ent_ff;
         end else if (op_ff == cbm_pkg::OP_WRITE && in_range) begin
            mem_we              = 1'b1;
            mem_wdata.kind      = bkind_ff;
            mem_wdata.device    = dev_ff;
            mem_wdata.index     = idx_ff;
            mem_wdata.threshold = bthr_ff;
         end
      end
   end

   assign rd_en   = (state_ff == ST_SCAN) && (scan_ff < EW'(ENTRIES));
   assign rd_addr = scan_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) bind_mem_ff[mem_waddr] <= mem_wdata;
      if (rd_en) rdata_ff <= bind_mem_ff[rd_addr];
   end

   // one match unit shared by every entry of the scan
   assign evt.kind   = op_ff[1:0];
   assign evt.device = dev_ff;
   assign evt.index  = idx_ff;
   assign evt.value  = val_ff;

   cbm_match u_match (
      .entry  (rdata_ff),
      .bound  (cmp_bound_ff),
      .evt    (evt),
      .result (match)
   );

   // packed press states of the player being reported
   always_comb begin
      report_word = '0;
      for (int p = 0; p < PLAYERS; p++) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (rp_ff == PW'(p)) report_word[2*s +: 2] = press_ff[p*SLOTS + s];
         end
      end
   end

   assign rpt_last = (rp_ff == PW'(PLAYERS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bound_ff     <= '0;
         raw_ff       <= '0;
         press_ff     <= '0;
         armed_ff     <= 1'b0;
         armed_ent_ff <= '0;
         cmp_vld_ff   <= 1'b0;
         scan_ff      <= '0;
         rp_ff        <= '0;
         cap_ff       <= 1'b0;
      end else begin
         // ACK and REPORT reload the register themselves when it drains
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_ACK && state_ff != ST_REPORT)
            rsp_valid_ff <= 1'b0;

         // scan pipeline: read issued this cycle is compared next cycle
         cmp_vld_ff   <= rd_en;
         cmp_idx_ff   <= rd_addr;
         cmp_bound_ff <= bound_ff[rd_addr];
         if (cmp_vld_ff && match.sel) raw_ff[cmp_idx_ff] <= match.hit;

         if (mem_we) bound_ff[mem_waddr] <= 1'b1;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  op_ff    <= req_ch.opcode;
                  dev_ff   <= req_ch.device;
                  idx_ff   <= req_ch.control_index;
                  val_ff   <= req_ch.value;
                  pl_ff    <= req_ch.player;
                  sl_ff    <= req_ch.slot;
                  bkind_ff <= req_ch.bind_kind;
                  bthr_ff  <= req_ch.bind_threshold;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               cap_ff <= is_event && armed_ff && qualify;
               if (is_event) begin
                  if (armed_ff && qualify) begin
                     armed_ff <= 1'b0;
                     state_ff <= ST_ACK;
                  end else begin
                     scan_ff  <= '0;
                     state_ff <= ST_SCAN;
                  end
               end else if (op_ff == cbm_pkg::OP_FRAME) begin
                  for (int e = 0; e < ENTRIES; e++) begin
                     if (raw_ff[e])
                        press_ff[e] <= (press_ff[e] == cbm_pkg::PS_IDLE) ?
                                       cbm_pkg::PS_PRESSED : cbm_pkg::PS_HELD;
                     else
                        press_ff[e] <= (press_ff[e] == cbm_pkg::PS_HELD) ?
                                       cbm_pkg::PS_RELEASED : cbm_pkg::PS_IDLE;
                  end
                  rp_ff    <= '0;
                  state_ff <= ST_REPORT;
               end else begin
                  if (op_ff == cbm_pkg::OP_ARM && in_range) begin
                     armed_ff     <= 1'b1;
                     armed_ent_ff <= req_ent;
                  end
                  state_ff <= ST_ACK;
               end
            end
            ST_SCAN: begin
               if (rd_en) scan_ff <= scan_ff + EW'(1);
               else if (!cmp_vld_ff) state_ff <= ST_ACK;
            end
            ST_ACK: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_report_ff   <= 1'b0;
                  rsp_player_ff   <= 1'b0;
                  rsp_states_ff   <= '0;
                  rsp_captured_ff <= cap_ff;
                  rsp_last_ff     <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            ST_REPORT: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_report_ff   <= 1'b1;
                  rsp_player_ff   <= rp_ff[0];
                  rsp_states_ff   <= report_word;
                  rsp_captured_ff <= 1'b0;
                  rsp_last_ff     <= rpt_last;
                  if (rpt_last) state_ff <= ST_IDLE;
                  else rp_ff <= rp_ff + PW'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* tb/sv/tb_control_binding_mapper.sv */
`timescale 1ns / 1ps
// Self-checking testbench for control_binding_mapper: corner requests, then random traffic.
module tb_control_binding_mapper;
   import cbm_pkg::*;

   localparam int PLAYERS         = DEFAULT_PLAYERS;
   localparam int SLOTS           = DEFAULT_SLOTS;
   localparam int ENTRIES         = PLAYERS * SLOTS;
   localparam int SCAN_CYCLES     = ENTRIES + 4;   // slowest request: full table scan
   localparam int RANDOM_REQUESTS = 1500;
   localparam int HOLD_CYCLES     = 400;           // long response back-pressure
   localparam int STALL_LIMIT     = 5000;          // cycles without any handshake
   localparam int MAX_REPORTED    = 10;
   localparam logic [2:0] OP_UNUSED = 3'd7;        // acknowledged, no effect

   typedef struct packed {
      logic [2:0]         opcode;
      logic [7:0]         device;
      logic [30:0]        control_index;
      logic signed [15:0] value;
      logic               player;
      logic [3:0]         slot;
      logic [1:0]         bind_kind;
      logic signed [15:0] bind_threshold;
   } request_t;

   typedef struct packed {
      logic        report;
      logic        report_player;
      logic [31:0] press_states;
      logic        captured;
      logic        last;
   } result_t;

   // Shadow of the mapper: binding table, raw bits, press states and rebind
   // arming. Each accepted request yields its expected responses in order.
   class press_scoreboard;
      entry_type  bind_tab [ENTRIES];
      bit         bound    [ENTRIES];
      bit         raw      [ENTRIES];
      logic [1:0] press    [ENTRIES];
      bit         armed;
      bit         armed_player;
      logic [3:0] armed_slot;
      result_t    expected_q [$];
      int         mismatches, requests_seen, results_seen, reports_seen, captures_seen;

      function new();
         foreach (bind_tab[e]) begin
            bind_tab[e] = '0;
            press[e]    = PS_IDLE;
         end
         armed_slot = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Rebind capture: overwrite the armed entry, drop arming, raw untouched.
      function void capture(logic [1:0] kind, logic [7:0] dev, logic [30:0] idx,
                            logic signed [15:0] thr);
         int e;
         e = int'(armed_player) * SLOTS + int'(armed_slot);
         bind_tab[e] = '{kind: kind, device: dev, index: idx, threshold: thr};
         bound[e]    = 1'b1;
         armed       = 1'b0;
      endfunction

      function void note_request(request_t r);
         result_t            ack;
         logic signed [15:0] val, thr;
         logic [31:0]        word;
         bit                 took, hit, down;
         int                 e, p, s;
         requests_seen++;
         ack  = '{report: 1'b0, report_player: 1'b0, press_states: '0, captured: 1'b0,
                  last: 1'b1};
         val  = r.value;
         down = (val != 0);
         if (r.opcode <= OP_BUTTON) begin
            took = 1'b0;
            if (armed) begin
               took = 1'b1;
               if (r.opcode == OP_KEY && down)
                  capture(KIND_KEY, KEY_DEVICE, r.control_index, '0);
               else if (r.opcode == OP_BUTTON && down)
                  capture(KIND_BUTTON, r.device, r.control_index, '0);
               else if (r.opcode == OP_AXIS && val >= AXIS_HI)
                  capture(KIND_AXIS, r.device, r.control_index, AXIS_HI);
               else if (r.opcode == OP_AXIS && val <= AXIS_LO)
                  capture(KIND_AXIS, r.device, r.control_index, AXIS_LO);
               else if (r.opcode == OP_HAT && val inside {16'sd1, 16'sd2, 16'sd4, 16'sd8})
                  capture(KIND_HAT, r.device, r.control_index, val);
               else
                  took = 1'b0;
            end
            if (took) begin
               ack.captured = 1'b1;
               captures_seen++;
            end else begin
               // event kinds share their encoding with binding kinds
               for (e = 0; e < ENTRIES; e++) begin
                  if (!bound[e] || bind_tab[e].kind != r.opcode[1:0] ||
                      bind_tab[e].index != r.control_index)
                     continue;
                  if (r.opcode != OP_KEY && bind_tab[e].device != r.device)
                     continue;
                  thr = bind_tab[e].threshold;
                  case (r.opcode)
                     OP_AXIS: hit = (thr >= 0) ? (val >= thr) : (val <= thr);
                     OP_HAT:  hit = ((thr & val) != 0);
                     default: hit = down;
                  endcase
                  raw[e] = hit;
               end
            end
            expected_q.push_back(ack);
         end else if (r.opcode == OP_FRAME) begin
            for (e = 0; e < ENTRIES; e++) begin
               if (raw[e])
                  press[e] = (press[e] == PS_IDLE) ? PS_PRESSED : PS_HELD;
               else
                  press[e] = (press[e] == PS_HELD) ? PS_RELEASED : PS_IDLE;
            end
            for (p = 0; p < PLAYERS; p++) begin
               word = '0;
               for (s = 0; s < SLOTS; s++)
                  word[2*s +: 2] = press[p*SLOTS + s];
               expected_q.push_back('{report: 1'b1, report_player: 1'(p), press_states: word,
                                      captured: 1'b0, last: 1'(p == PLAYERS - 1)});
            end
         end else begin
            if (r.opcode == OP_ARM && r.player < PLAYERS && r.slot < SLOTS) begin
               armed        = 1'b1;
               armed_player = r.player;
               armed_slot   = r.slot;
            end else if (r.opcode == OP_WRITE && r.player < PLAYERS && r.slot < SLOTS) begin
               e = int'(r.player) * SLOTS + int'(r.slot);
               bind_tab[e] = '{kind: r.bind_kind, device: r.device, index: r.control_index,
                               threshold: r.bind_threshold};
               bound[e]    = 1'b1;
            end
            expected_q.push_back(ack);
         end
      endfunction

      function void flag(string what, result_t want, result_t got);
         mismatches++;
         if (mismatches <= MAX_REPORTED)
            $display("%0t %s: expected rep=%0b pl=%0b states=%08h cap=%0b last=%0b, got rep=%0b pl=%0b states=%08h cap=%0b last=%0b",
                     $realtime, what, want.report, want.report_player, want.press_states,
                     want.captured, want.last, got.report, got.report_player,
                     got.press_states, got.captured, got.last);
      endfunction

      function void check_result(result_t got);
         result_t want;
         results_seen++;
         if (got.report === 1'b1)
            reports_seen++;
         if (expected_q.size() == 0) begin
            flag("response with nothing outstanding", '0, got);
            return;
         end
         want = expected_q.pop_front();
         if (got.report !== want.report || got.report_player !== want.report_player ||
             got.press_states !== want.press_states || got.captured !== want.captured ||
             got.last !== want.last)
            flag("response mismatch", want, got);
      endfunction

      function void check_drained();
         if (expected_q.size() != 0) begin
            $display("%0d expected responses never arrived", expected_q.size());
            mismatches += expected_q.size();
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   cbm_req_if req_bus ();
   cbm_rsp_if rsp_bus ();

   control_binding_mapper dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   press_scoreboard sb = new();

   bit          quiet_phase  = 1'b0;  // both sides stop idling
   int          hold_request = 0;     // receiver back-pressure length, taken once
   int          idle_cycles  = 0;
   logic [7:0]  dev_pool [4];
   logic [30:0] idx_pool [6];

   // 2 ns clock
   always #1 clock = ~clock;

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   function automatic int next_gap();
      return quiet_phase ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic request_t make_request(logic [2:0] op, logic [7:0] dev,
                                             logic [30:0] idx, logic signed [15:0] val,
                                             logic pl, logic [3:0] sl, logic [1:0] kind,
                                             logic signed [15:0] thr);
      return '{opcode: op, device: dev, control_index: idx, value: val, player: pl,
               slot: sl, bind_kind: kind, bind_threshold: thr};
   endfunction

   // Axis positions cluster on the capture and binding thresholds.
   function automatic logic signed [15:0] axis_value();
      logic signed [15:0] corner [10];
      corner = '{AXIS_HI, AXIS_HI - 1, AXIS_HI + 1, AXIS_LO, AXIS_LO - 1, AXIS_LO + 1,
                 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
      if ($urandom_range(0, 1) != 0)
         return corner[$urandom_range(0, 9)];
      return 16'($urandom);
   endfunction

   // Mostly well-formed traffic over a small device/index pool so that events
   // hit bindings; a few fully random requests as noise.
   function automatic request_t random_request();
      request_t r;
      int       pick;
      r.opcode         = 3'($urandom);
      r.device         = 8'($urandom);
      r.control_index  = 31'($urandom);
      r.value          = 16'($urandom);
      r.player         = 1'($urandom);
      r.slot           = 4'($urandom);
      r.bind_kind      = 2'($urandom);
      r.bind_threshold = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 3)
         return r;
      if ($urandom_range(0, 9) != 0) begin
         r.device        = dev_pool[$urandom_range(0, 3)];
         r.control_index = idx_pool[$urandom_range(0, 5)];
      end
      if (pick < 16) begin
         r.opcode = OP_WRITE;
         case (r.bind_kind)
            KIND_AXIS: r.bind_threshold = axis_value();
            KIND_HAT:  if ($urandom_range(0, 1) != 0) r.bind_threshold = 16'($urandom_range(1, 15));
            default: ;
         endcase
      end else if (pick < 21) begin
         r.opcode = OP_ARM;
      end else if (pick < 40) begin
         r.opcode = OP_FRAME;
      end else if (pick < 42) begin
         r.opcode = OP_UNUSED;
      end else begin
         r.opcode = 3'($urandom_range(OP_KEY, OP_BUTTON));
         case (r.opcode)
            OP_AXIS: r.value = axis_value();
            OP_HAT: begin
               case ($urandom_range(0, 3))
                  0, 1: r.value = 16'(1 << $urandom_range(0, 3));   // single direction
                  2:    r.value = '0;
                  default: ;
               endcase
            end
            default: if ($urandom_range(0, 2) == 0) r.value = '0;   // key/button up
         endcase
      end
      return r;
   endfunction

   // Hold the request until accepted, record it, then optionally drop valid.
   // With gap_after == 0 valid stays high for the next request.
   task automatic send_request(request_t r, int gap_after);
      req_bus.opcode         <= r.opcode;
      req_bus.device         <= r.device;
      req_bus.control_index  <= r.control_index;
      req_bus.value          <= r.value;
      req_bus.player         <= r.player;
      req_bus.slot           <= r.slot;
      req_bus.bind_kind      <= r.bind_kind;
      req_bus.bind_threshold <= r.bind_threshold;
      req_bus.valid          <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
      if (gap_after > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap_after) @(posedge clock);
      end
   endtask

   // Response side: random stall before each response, one long hold-off on request.
   initial begin : response_side
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request > 0) begin
            stall        = hold_request;
            hold_request = 0;
         end else begin
            stall = quiet_phase ? 0 : $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         sb.check_result('{rsp_bus.report, rsp_bus.report_player, rsp_bus.press_states,
                           rsp_bus.captured, rsp_bus.last});
      end
   end

   initial begin : stimulus
      request_t corner_q [$];
      request_t r;
      int       sent;
      bit       held, paused;

      req_bus.valid          <= 1'b0;
      req_bus.opcode         <= OP_KEY;
      req_bus.device         <= '0;
      req_bus.control_index  <= '0;
      req_bus.value          <= '0;
      req_bus.player         <= 1'b0;
      req_bus.slot           <= '0;
      req_bus.bind_kind      <= KIND_KEY;
      req_bus.bind_threshold <= '0;
      rsp_bus.ready          <= 1'b0;

      dev_pool = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
      idx_pool = '{31'd0, 31'h7FFF_FFFF, 31'($urandom), 31'($urandom), 31'($urandom),
                   31'($urandom)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- corner cases ---
      // event against an all-unbound table
      corner_q.push_back(make_request(OP_KEY, 8'h00, 31'd0, 16'sd1, 1'b0, 4'd0, KIND_KEY, '0));
      // one binding of every kind, at extreme indexes, devices and thresholds
      corner_q.push_back(make_request(OP_WRITE, 8'h00, 31'h7FFF_FFFF, '0, 1'b0, 4'd0,
                                      KIND_KEY, 16'sh7FFF));
      corner_q.push_back(make_request(OP_WRITE, 8'hFF, 31'd0, '0, 1'b1, 4'd15,
                                      KIND_AXIS, 16'sh8000));
      corner_q.push_back(make_request(OP_WRITE, 8'h55, 31'd3, '0, 1'b0, 4'd5,
                                      KIND_HAT, 16'sh8000));
      corner_q.push_back(make_request(OP_WRITE, 8'hAA, 31'd12345, '0, 1'b1, 4'd3,
                                      KIND_BUTTON, '0));
      corner_q.push_back(make_request(OP_WRITE, 8'h0F, 31'h4000_0000, '0, 1'b0, 4'd9,
                                      KIND_AXIS, 16'sh7FFF));
      // key ignores device; negative axis threshold; hat on the sign bit; button down
      corner_q.push_back(make_request(OP_KEY, 8'h12, 31'h7FFF_FFFF, 16'sd1, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      corner_q.push_back(make_request(OP_AXIS, 8'hFF, 31'd0, 16'sh8000, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      corner_q.push_back(make_request(OP_HAT, 8'h55, 31'd3, 16'sh8000, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      corner_q.push_back(make_request(OP_BUTTON, 8'hAA, 31'd12345, 16'shFFFF, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      corner_q.push_back(make_request(OP_AXIS, 8'h0F, 31'h4000_0000, 16'sh7FFF, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      // pressed, then held
      corner_q.push_back(make_request(OP_FRAME, '0, '0, '0, 1'b0, 4'd0, KIND_KEY, '0));
      corner_q.push_back(make_request(OP_FRAME, '0, '0, '0, 1'b0, 4'd0, KIND_KEY, '0));
      // key up, then released
      corner_q.push_back(make_request(OP_KEY, 8'h00, 31'h7FFF_FFFF, '0, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      corner_q.push_back(make_request(OP_FRAME, '0, '0, '0, 1'b0, 4'd0, KIND_KEY, '0));
      // armed: axis short of half scale is matched normally, then hat capture
      corner_q.push_back(make_request(OP_ARM, '0, '0, '0, 1'b1, 4'd7, KIND_KEY, '0));
      corner_q.push_back(make_request(OP_AXIS, 8'hFF, 31'd0, AXIS_HI - 1, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      corner_q.push_back(make_request(OP_HAT, 8'h01, 31'd9, 16'sd8, 1'b0, 4'd0, KIND_KEY, '0));
      // rearm replaces the slot; low axis capture
      corner_q.push_back(make_request(OP_ARM, '0, '0, '0, 1'b0, 4'd1, KIND_KEY, '0));
      corner_q.push_back(make_request(OP_ARM, '0, '0, '0, 1'b0, 4'd2, KIND_KEY, '0));
      corner_q.push_back(make_request(OP_AXIS, 8'h03, 31'd4, AXIS_LO, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      // key capture, high axis capture, button capture
      corner_q.push_back(make_request(OP_ARM, '0, '0, '0, 1'b1, 4'd0, KIND_KEY, '0));
      corner_q.push_back(make_request(OP_KEY, 8'h21, 31'd77, 16'sd5, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      corner_q.push_back(make_request(OP_ARM, '0, '0, '0, 1'b0, 4'd4, KIND_KEY, '0));
      corner_q.push_back(make_request(OP_AXIS, 8'h07, 31'd6, AXIS_HI, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      corner_q.push_back(make_request(OP_ARM, '0, '0, '0, 1'b1, 4'd1, KIND_KEY, '0));
      corner_q.push_back(make_request(OP_BUTTON, 8'h09, 31'd8, 16'sd1, 1'b0, 4'd0,
                                      KIND_KEY, '0));
      // unused opcode, then a frame to see the captures left raw alone
      corner_q.push_back(make_request(OP_UNUSED, '0, '0, '0, 1'b0, 4'd0, KIND_KEY, '0));
      corner_q.push_back(make_request(OP_FRAME, '0, '0, '0, 1'b0, 4'd0, KIND_KEY, '0));

      foreach (corner_q[i])
         send_request(corner_q[i], (i == corner_q.size() - 1) ? 1 : next_gap());
      while (sb.pending() != 0) @(posedge clock);

      // --- random traffic ---
      sent   = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (sent < RANDOM_REQUESTS) begin
         r = random_request();
         if (r.opcode != OP_UNUSED)
            sent++;
         quiet_phase = (sent >= 200 && sent < 300) || (sent >= 1200 && sent < 1300);
         // long receiver hold-off while requests keep coming: the block backs up
         if (!held && sent >= 500) begin
            held         = 1'b1;
            hold_request = HOLD_CYCLES;
         end
         if (!paused && sent >= 1000) begin
            // sender stops until every response is back
            paused = 1'b1;
            send_request(r, 1);
            while (sb.pending() != 0) @(posedge clock);
         end else begin
            send_request(r, (sent == RANDOM_REQUESTS) ? 1 : next_gap());
         end
      end
      quiet_phase = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * SCAN_CYCLES) @(posedge clock);
      sb.check_drained();

      $display("covered %0d requests (corner cases, random bindings, events, rebinds, ticks), %0d responses",
               sb.requests_seen, sb.results_seen);
      $display("covered %0d frame reports, %0d rebind captures, long response hold-off, mid-run drain; %0d mismatches",
               sb.reports_seen, sb.captures_seen, sb.mismatches);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* control_binding_mapper.f */
rtl/cbm_pkg.sv
rtl/cbm_req_if.sv
rtl/cbm_match.sv
rtl/control_binding_mapper.sv
tb/sv/tb_control_binding_mapper.sv
